// ----- hw/rtl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the k nearest neighbor finder.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_K      = 8;
  localparam int COORD_W    = 8;

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int KIDX_W = $clog2(MAX_K);
  localparam int K_W    = 4;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_K_NEIGHBORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;

  // Request and status codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_RANGE  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [PIDX_W-1:0]  point_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0] neighbor_index;
    logic [DIST_W-1:0] dist_squared;
    logic [KIDX_W-1:0] rank;
    logic              last;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // Control from the sequencer to the best list.
  typedef struct packed {
    logic clr;
    logic ins;
  } best_ctl_t;

endpackage

// ----- hw/rtl/knn_point_mem.sv -----
// ----------------------------------------------------------------------------
// knn_point_mem
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module knn_point_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [knn_pkg::PIDX_W-1:0] wr_addr,
  input  knn_pkg::point_t           wr_data,
  input  logic [knn_pkg::PIDX_W-1:0] rd_addr,
  output knn_pkg::point_t           rd_data
);

  knn_pkg::point_t mem [knn_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/knn_dist_unit.sv -----
// ----------------------------------------------------------------------------
// knn_dist_unit
// Shared squared distance unit: absolute differences, then squares, then sum.
// Two register stages; a tag index travels along with each point.
// ----------------------------------------------------------------------------
module knn_dist_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [knn_pkg::PIDX_W-1:0] in_tag,
  input  knn_pkg::point_t            q_pt,
  input  knn_pkg::point_t            p_pt,
  output logic                       out_vld,
  output logic [knn_pkg::PIDX_W-1:0] out_tag,
  output logic [knn_pkg::DIST_W-1:0] out_dist
);

  logic [knn_pkg::COORD_W-1:0] dx_r, dy_r;
  logic [knn_pkg::PIDX_W-1:0]  tag1_r, tag2_r;
  logic                        vld1_r, vld2_r;
  logic [knn_pkg::SQ_W-1:0]    sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= (q_pt.x >= p_pt.x) ? q_pt.x - p_pt.x : p_pt.x - q_pt.x;
    dy_r   <= (q_pt.y >= p_pt.y) ? q_pt.y - p_pt.y : p_pt.y - q_pt.y;
    tag1_r <= in_tag;
    sqx_r  <= knn_pkg::SQ_W'(dx_r) * knn_pkg::SQ_W'(dx_r);
    sqy_r  <= knn_pkg::SQ_W'(dy_r) * knn_pkg::SQ_W'(dy_r);
    tag2_r <= tag1_r;
  end

  assign out_vld  = vld2_r;
  assign out_tag  = tag2_r;
  assign out_dist = {1'b0, sqx_r} + {1'b0, sqy_r};

endmodule

// ----- hw/rtl/knn_best_list.sv -----
// ----------------------------------------------------------------------------
// knn_best_list
// Sorted list of the best candidates so far, ascending distance.
// An insert shifts the larger entries down by one slot.
// ----------------------------------------------------------------------------
module knn_best_list (
  input  logic                       clk,
  input  logic                       rst_n,
  input  knn_pkg::best_ctl_t         ctl,
  input  logic [knn_pkg::K_W-1:0]    k_sat,
  input  logic [knn_pkg::DIST_W-1:0] ins_dist,
  input  logic [knn_pkg::PIDX_W-1:0] ins_idx,
  input  logic [knn_pkg::KIDX_W-1:0] rd_sel,
  output logic [knn_pkg::DIST_W-1:0] rd_dist,
  output logic [knn_pkg::PIDX_W-1:0] rd_idx,
  output logic [knn_pkg::K_W-1:0]    cnt
);

  logic [knn_pkg::DIST_W-1:0] dist_r [knn_pkg::MAX_K];
  logic [knn_pkg::PIDX_W-1:0] idx_r  [knn_pkg::MAX_K];
  logic [knn_pkg::K_W-1:0]    cnt_r;
  logic [knn_pkg::MAX_K-1:0]  lt;

  // Empty slots hold all ones, which no real distance reaches, so the
  // compare vector is monotonic over the used slots.
  always_comb begin
    for (int i = 0; i < knn_pkg::MAX_K; i++) begin
      lt[i] = ins_dist < dist_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < knn_pkg::MAX_K; i++) begin
        dist_r[i] <= '1;
        idx_r[i]  <= '0;
      end
    end else if (ctl.clr) begin
      cnt_r <= '0;
      for (int i = 0; i < knn_pkg::MAX_K; i++) begin
        dist_r[i] <= '1;
        idx_r[i]  <= '0;
      end
    end else if (ctl.ins) begin
      for (int i = 0; i < knn_pkg::MAX_K; i++) begin
        if ((i < int'(k_sat)) && lt[i]) begin
          if (i == 0) begin
            dist_r[i] <= ins_dist;
            idx_r[i]  <= ins_idx;
          end else if (!lt[i-1]) begin
            dist_r[i] <= ins_dist;
            idx_r[i]  <= ins_idx;
          end else begin
            dist_r[i] <= dist_r[i-1];
            idx_r[i]  <= idx_r[i-1];
          end
        end
      end
      if (cnt_r < k_sat) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign rd_dist = dist_r[rd_sel];
  assign rd_idx  = idx_r[rd_sel];
  assign cnt     = cnt_r;

endmodule

// ----- hw/rtl/knn_neighbor_finder.sv -----
// ----------------------------------------------------------------------------
// knn_neighbor_finder
// Brute-force k nearest neighbor search over a store of 2-D points.
//
//   channel  ports                               handshake
//   -------  ----------------------------------  ------------------------
//   input    start, busy, in_data                start & !busy
//   result   out_valid, out_data                 strobe, one cycle each
//   config   cfg_valid, cfg_ready, cfg_index,    cfg_valid & cfg_ready
//            cfg_data
//
// A load is written at its transfer and busy stays low. A query keeps busy high
// while it reads the queried point, scans the store, drains the pipeline and
// emits its results: one point read from the store and one distance per cycle
// through the shared unit, then one result per cycle.
// An out-of-range query gives its single error result in the cycle after the
// transfer. Reset is synchronous; the store itself is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module knn_neighbor_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  knn_pkg::in_item_t                in_data,
  output logic                             out_valid,
  output knn_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [knn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_QLOAD  = 7'b0000010,
    S_QLATCH = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_ERR    = 7'b1000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [knn_pkg::K_W-1:0]      k_reg_r;
  logic [knn_pkg::CNT_W-1:0]    count_reg_r;
  logic [knn_pkg::K_W-1:0]      k_sat;
  logic [knn_pkg::CNT_W-1:0]    count_sat;
  logic [knn_pkg::K_W-1:0]      k_r;
  logic [knn_pkg::CNT_W-1:0]    count_r;
  logic [knn_pkg::PIDX_W-1:0]   q_idx_r;
  knn_pkg::point_t              q_pt_r;
  logic [knn_pkg::PIDX_W-1:0]   j_r, j_nxt;
  logic [1:0]                   drain_r, drain_nxt;
  logic [knn_pkg::KIDX_W-1:0]   rank_r, rank_nxt;
  logic                         rd_vld_r;
  logic [knn_pkg::PIDX_W-1:0]   rd_tag_r;

  logic                         accept;
  logic                         wr_en;
  logic [knn_pkg::PIDX_W-1:0]   rd_addr;
  knn_pkg::point_t              wr_pt, rd_pt;
  logic                         last_issue;

  logic                         dist_vld;
  logic [knn_pkg::PIDX_W-1:0]   dist_tag;
  logic [knn_pkg::DIST_W-1:0]   dist_val;

  knn_pkg::best_ctl_t           best_ctl;
  logic [knn_pkg::DIST_W-1:0]   best_dist;
  logic [knn_pkg::PIDX_W-1:0]   best_idx;
  logic [knn_pkg::K_W-1:0]      best_cnt;
  logic                         emit_last;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_reg_r     <= knn_pkg::K_W'(4);
      count_reg_r <= knn_pkg::CNT_W'(200);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        knn_pkg::REG_K_NEIGHBORS: k_reg_r     <= cfg_data[knn_pkg::K_W-1:0];
        knn_pkg::REG_POINT_COUNT: count_reg_r <= cfg_data[knn_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (k_reg_r == '0) begin
      k_sat = knn_pkg::K_W'(1);
    end else if (k_reg_r > knn_pkg::K_W'(knn_pkg::MAX_K)) begin
      k_sat = knn_pkg::K_W'(knn_pkg::MAX_K);
    end else begin
      k_sat = k_reg_r;
    end
    if (count_reg_r < knn_pkg::CNT_W'(2)) begin
      count_sat = knn_pkg::CNT_W'(2);
    end else if (count_reg_r > knn_pkg::CNT_W'(knn_pkg::MAX_POINTS)) begin
      count_sat = knn_pkg::CNT_W'(knn_pkg::MAX_POINTS);
    end else begin
      count_sat = count_reg_r;
    end
  end

  // Point store.
  assign wr_en   = accept && (in_data.req_type == knn_pkg::REQ_LOAD);
  assign wr_pt.x = in_data.coord_x;
  assign wr_pt.y = in_data.coord_y;
  assign rd_addr = (state_r == S_QLOAD) ? q_idx_r : j_r;

  knn_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.point_index),
    .wr_data (wr_pt),
    .rd_addr (rd_addr),
    .rd_data (rd_pt)
  );

  assign last_issue = ({1'b0, j_r} == count_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    drain_nxt = drain_r;
    rank_nxt  = rank_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.req_type == knn_pkg::REQ_QUERY)) begin
          if ({1'b0, in_data.point_index} >= count_sat) begin
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_QLOAD;
          end
        end
        j_nxt    = '0;
        drain_nxt = '0;
        rank_nxt = '0;
      end
      S_QLOAD:  state_nxt = S_QLATCH;
      S_QLATCH: state_nxt = S_SCAN;
      S_SCAN: begin
        j_nxt = j_r + 1'b1;
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'd2) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        rank_nxt = rank_r + 1'b1;
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      j_r      <= '0;
      drain_r  <= '0;
      rank_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      drain_r  <= drain_nxt;
      rank_r   <= rank_nxt;
      // The queried point itself is read but never ranked.
      rd_vld_r <= (state_r == S_SCAN) && (j_r != q_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= j_r;
    if (accept) begin
      q_idx_r <= in_data.point_index;
      k_r     <= k_sat;
      count_r <= count_sat;
    end
    if (state_r == S_QLATCH) begin
      q_pt_r <= rd_pt;
    end
  end

  knn_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .in_tag   (rd_tag_r),
    .q_pt     (q_pt_r),
    .p_pt     (rd_pt),
    .out_vld  (dist_vld),
    .out_tag  (dist_tag),
    .out_dist (dist_val)
  );

  assign best_ctl.clr = accept && (in_data.req_type == knn_pkg::REQ_QUERY);
  assign best_ctl.ins = dist_vld;

  knn_best_list u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (best_ctl),
    .k_sat    (k_r),
    .ins_dist (dist_val),
    .ins_idx  (dist_tag),
    .rd_sel   (rank_r),
    .rd_dist  (best_dist),
    .rd_idx   (best_idx),
    .cnt      (best_cnt)
  );

  assign emit_last = ({1'b0, rank_r} + 1'b1 == best_cnt);

  always_comb begin
    out_valid = 1'b0;
    out_data  = '0;
    case (state_r)
      S_EMIT: begin
        out_valid               = 1'b1;
        out_data.neighbor_index = best_idx;
        out_data.dist_squared   = best_dist;
        out_data.rank           = rank_r;
        out_data.last           = emit_last;
        out_data.status         = knn_pkg::ST_OK;
      end
      S_ERR: begin
        out_valid       = 1'b1;
        out_data.last   = 1'b1;
        out_data.status = knn_pkg::ST_RANGE;
      end
      default: ;
    endcase
  end

endmodule

// ----- dv/tb_knn_neighbor_finder.sv -----
// ----------------------------------------------------------------------------
// tb_knn_neighbor_finder
// Self-checking testbench for the k nearest neighbor finder. It loads points,
// writes the neighbor count and point count registers, and sends queries,
// first in a short directed sequence and then in random phases. A
// scoreboard keeps its own copy of the point store and computes the expected
// neighbor list of every query. Each result strobe is compared with it.
// ----------------------------------------------------------------------------
module tb_knn_neighbor_finder;
  import knn_pkg::*;

  // Register slots past the defined ones; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int RANDOM_ITEMS  = 470;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 200;

  class neighbor_scoreboard;
    logic [K_W-1:0]     k_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COORD_W-1:0] pt_x [MAX_POINTS];
    logic [COORD_W-1:0] pt_y [MAX_POINTS];
    out_item_t          pending_neighbors [$];
    int                 errors;
    int                 checked;

    function new();
      k_reg     = 4;
      count_reg = 200;
      errors    = 0;
      checked   = 0;
    endfunction

    function int scan_count();
      if (count_reg < 2) return 2;
      if (count_reg > MAX_POINTS) return MAX_POINTS;
      return int'(count_reg);
    endfunction

    function int k_limit();
      if (k_reg < 1) return 1;
      if (k_reg > MAX_K) return MAX_K;
      return int'(k_reg);
    endfunction

    function int pending();
      return pending_neighbors.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_K_NEIGHBORS: k_reg = data[K_W-1:0];
        REG_POINT_COUNT: count_reg = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Loads update the store; queries rank every other point in index order.
    // A strict less-than on insertion keeps the lower index first on ties.
    function void predict_neighbors(in_item_t item);
      int                lim;
      int                kk;
      int                n;
      int                pos;
      int                dx;
      int                dy;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] near_d [MAX_K];
      logic [PIDX_W-1:0] near_i [MAX_K];
      out_item_t         res;
      if (item.req_type == REQ_LOAD) begin
        pt_x[item.point_index] = item.coord_x;
        pt_y[item.point_index] = item.coord_y;
        return;
      end
      lim = scan_count();
      kk  = k_limit();
      if (item.point_index >= lim) begin
        res        = '0;
        res.last   = 1'b1;
        res.status = ST_RANGE;
        pending_neighbors.push_back(res);
        return;
      end
      n = 0;
      for (int j = 0; j < lim; j++) begin
        if (j == item.point_index) continue;
        dx = int'(pt_x[j]) - int'(pt_x[item.point_index]);
        dy = int'(pt_y[j]) - int'(pt_y[item.point_index]);
        d  = DIST_W'(dx * dx + dy * dy);
        if (n == kk && d >= near_d[kk-1]) continue;
        pos = (n < kk) ? n : kk - 1;
        while (pos > 0 && d < near_d[pos-1]) begin
          near_d[pos] = near_d[pos-1];
          near_i[pos] = near_i[pos-1];
          pos--;
        end
        near_d[pos] = d;
        near_i[pos] = PIDX_W'(j);
        if (n < kk) n++;
      end
      for (int r = 0; r < n; r++) begin
        res.neighbor_index = near_i[r];
        res.dist_squared   = near_d[r];
        res.rank           = KIDX_W'(r);
        res.last           = (r == n - 1);
        res.status         = ST_OK;
        pending_neighbors.push_back(res);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_neighbor(out_item_t got);
      out_item_t want;
      string     diffs;
      if (pending_neighbors.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx %0d dist %0d rank %0d last %b st %b",
                                  got.neighbor_index, got.dist_squared, got.rank,
                                  got.last, got.status));
        return;
      end
      want = pending_neighbors.pop_front();
      checked++;
      diffs = "";
      if (got.neighbor_index !== want.neighbor_index) diffs = {diffs, " neighbor_index"};
      if (got.dist_squared !== want.dist_squared) diffs = {diffs, " dist_squared"};
      if (got.rank !== want.rank) diffs = {diffs, " rank"};
      if (got.last !== want.last) diffs = {diffs, " last"};
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (diffs != "")
        report_mismatch($sformatf(
          "result %0d wrong in%s: got %0d/%0d/%0d/%b/%b, expected %0d/%0d/%0d/%b/%b",
          checked, diffs, got.neighbor_index, got.dist_squared, got.rank, got.last,
          got.status, want.neighbor_index, want.dist_squared, want.rank, want.last,
          want.status));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_item_t              in_data   = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_ready;

  neighbor_scoreboard sb = new();

  bit loaded [MAX_POINTS];
  int filled     = 0;
  bit idle_on    = 1'b1;
  int n_loads    = 0;
  int n_queries  = 0;
  int n_range    = 0;
  int n_settings = 0;

  knn_neighbor_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL knn_neighbor_finder");
    $finish;
  end

  // Results cannot be held off, so every strobe is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_neighbor(out_data);
  end

  function automatic in_item_t random_item();
    in_item_t item;
    item.req_type    = 1'($urandom_range(0, 1));
    item.point_index = PIDX_W'($urandom_range(0, MAX_POINTS - 1));
    item.coord_x     = COORD_W'($urandom_range(0, 255));
    item.coord_y     = COORD_W'($urandom_range(0, 255));
    return item;
  endfunction

  // Half the coordinates come from a tight cluster so that equal distances
  // show up often.
  function automatic int pick_coord();
    if ($urandom_range(0, 1)) return 100 + $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 99) < 34) begin
      start   <= 1'b0;
      in_data <= random_item();
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Waits for the transfer of the item, then runs an optional idle gap.
  task automatic send_item(input in_item_t item);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    if (item.req_type == REQ_LOAD) n_loads++;
    else begin
      n_queries++;
      if (item.point_index >= sb.scan_count()) n_range++;
    end
    sb.predict_neighbors(item);
    idle_gap();
  endtask

  task automatic load_point(input int idx, input int x, input int y);
    in_item_t item;
    item.req_type    = REQ_LOAD;
    item.point_index = PIDX_W'(idx);
    item.coord_x     = COORD_W'(x);
    item.coord_y     = COORD_W'(y);
    send_item(item);
    loaded[idx] = 1'b1;
    while (filled < MAX_POINTS && loaded[filled]) filled++;
  endtask

  task automatic query_point(input int idx);
    in_item_t item;
    item             = random_item();
    item.req_type    = REQ_QUERY;
    item.point_index = PIDX_W'(idx);
    send_item(item);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int k_val;
    int c_val;
    int lim;
    int pick;
    int n_items;
    int rand_items;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. At the reset count of 200 the top index is out of range.
    query_point(255);
    wait_drained();
    write_reg(REG_K_NEIGHBORS, 16'h0008);
    write_reg(REG_POINT_COUNT, 16'h0002);
    load_point(0, 0, 0);
    load_point(1, 255, 255);
    query_point(0);
    query_point(1);
    query_point(2);
    wait_drained();
    // k of zero saturates to one; only the low nine bits set the count.
    write_reg(REG_K_NEIGHBORS, 16'h0000);
    write_reg(REG_POINT_COUNT, 16'hFE04);
    load_point(2, 255, 255);
    load_point(3, 0, 0);
    query_point(0);
    query_point(1);
    query_point(4);
    wait_drained();
    write_reg(REG_K_NEIGHBORS, 16'hFFF3);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    // Both queries see two points at an equal distance.
    query_point(2);
    query_point(3);
    wait_drained();
    write_reg(REG_K_NEIGHBORS, 16'h000F);
    write_reg(REG_POINT_COUNT, 16'h0001);
    query_point(1);
    query_point(3);
    load_point(255, 128, 77);
    load_point(1, 3, 4);
    wait_drained();
    write_reg(REG_POINT_COUNT, 16'h0000);
    query_point(0);

    // Random phases: a register setting, the loads that the scan needs,
    // then a mix of queries, out-of-range queries and overwriting loads.
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       k_val = 1;
        1:       k_val = MAX_K;
        2:       k_val = 0;
        3:       k_val = $urandom_range(9, 15);
        default: k_val = $urandom_range(1, MAX_K);
      endcase
      case (phase)
        0:       c_val = $urandom_range(2, 12);
        2:       c_val = MAX_POINTS;
        5:       c_val = 511;
        default: begin
          case ($urandom_range(0, 9))
            0:       c_val = $urandom_range(0, 1);
            1:       c_val = MAX_POINTS;
            2:       c_val = $urandom_range(MAX_POINTS + 1, 511);
            3, 4:    c_val = $urandom_range(2, MAX_POINTS);
            default: c_val = $urandom_range(2, 40);
          endcase
        end
      endcase
      write_reg(REG_K_NEIGHBORS, {12'($urandom), 4'(k_val)});
      write_reg(REG_POINT_COUNT, {7'($urandom), 9'(c_val)});
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      n_settings++;

      // Phase three runs back to back with no random idle gaps.
      idle_on = (phase != 3);
      lim     = sb.scan_count();
      while (filled < lim) begin
        load_point(filled, pick_coord(), pick_coord());
        rand_items++;
      end

      n_items = (phase == 3) ? 40 : $urandom_range(8, 30);
      repeat (n_items) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 60)
          query_point($urandom_range(0, lim - 1));
        else if (pick < 70 && lim < MAX_POINTS)
          query_point($urandom_range(lim, MAX_POINTS - 1));
        else
          load_point($urandom_range(0, MAX_POINTS - 1), pick_coord(), pick_coord());
        rand_items++;
      end
      phase++;
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d loads and %0d queries (%0d out of range) over %0d settings.",
             n_loads, n_queries, n_range, n_settings);
    $display("Compared %0d neighbor results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS knn_neighbor_finder");
    end else begin
      $display("FAIL knn_neighbor_finder");
    end
    $finish;
  end

endmodule
